// ===== rtl/core/gwlm_pkg.sv =====
// ----------------------------------------------------------------------------
// gwlm_pkg - shared definitions for the wildcard list matcher
// Sizes, character codes, command codes and the structs between modules.
// ----------------------------------------------------------------------------
package gwlm_pkg;

	localparam int PatLen  = 32;
	localparam int CntW    = $clog2(PatLen + 1);
	localparam int IdxW    = (PatLen > 1) ? $clog2(PatLen) : 1;
	localparam int PosN    = PatLen + 1;
	localparam int PropLvl = (PosN > 1) ? $clog2(PosN) : 1;

	localparam logic [7:0] ChStar  = 8'h2A;
	localparam logic [7:0] ChOne   = 8'h3F;
	localparam logic [7:0] ChSep   = 8'h3B;
	localparam logic [7:0] ChUpA   = 8'h41;
	localparam logic [7:0] ChUpZ   = 8'h5A;
	localparam logic [7:0] CaseBit = 8'h20;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_SUBJECT = 2'd2,
		CMD_END     = 2'd3
	} cmd_t;

	// Control from the top level to the pattern store.
	typedef struct packed {
		logic       clear;
		logic       append;
		logic [7:0] wdata;
	} store_ctrl_t;

	// Control from the top level to the position tracker.
	typedef struct packed {
		logic restart;
		logic step;
	} nfa_ctrl_t;

	// Per-position views of the stored pattern, against the current beat.
	typedef struct packed {
		logic [PosN-1:0]   start;
		logic [PosN-1:0]   prop;
		logic [PatLen-1:0] star;
		logic [PatLen-1:0] lit;
		logic [PosN-1:0]   accept;
		logic              overflow;
	} pat_info_t;

endpackage

// ===== rtl/core/gwlm_pattern_store.sv =====
// ----------------------------------------------------------------------------
// gwlm_pattern_store - pattern list registers and per-position decode
// Holds the pattern bytes, fill count and overflow flag, and decodes every
// position in parallel against the subject byte in the input register.
// ----------------------------------------------------------------------------
module gwlm_pattern_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gwlm_pkg::store_ctrl_t ctrl,
	input  logic [7:0]            char_code,
	input  logic                  case_sensitive,
	output gwlm_pkg::pat_info_t   info
);

	logic [7:0]                  store_q [gwlm_pkg::PatLen];
	logic [gwlm_pkg::CntW-1:0]   count_q;
	logic                        overflow_q;

	logic [gwlm_pkg::PatLen-1:0] valid;
	logic [gwlm_pkg::PatLen-1:0] is_star;
	logic [gwlm_pkg::PatLen-1:0] is_sep;
	logic [gwlm_pkg::PatLen-1:0] eq;
	logic [gwlm_pkg::PatLen-1:0] any_one;
	logic [7:0]                  char_f;

	function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
		if (!cs && c >= gwlm_pkg::ChUpA && c <= gwlm_pkg::ChUpZ) begin
			return c | gwlm_pkg::CaseBit;
		end
		return c;
	endfunction

	always_ff @(posedge clk) begin
		if (ctrl.append && count_q < gwlm_pkg::CntW'(gwlm_pkg::PatLen)) begin
			store_q[count_q[gwlm_pkg::IdxW-1:0]] <= ctrl.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (ctrl.clear) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (ctrl.append) begin
			if (count_q < gwlm_pkg::CntW'(gwlm_pkg::PatLen)) begin
				count_q <= count_q + 1'b1;
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	assign char_f = fold(char_code, case_sensitive);

	always_comb begin
		for (int i = 0; i < gwlm_pkg::PatLen; i++) begin
			valid[i]   = gwlm_pkg::CntW'(i) < count_q;
			is_star[i] = valid[i] && store_q[i] == gwlm_pkg::ChStar;
			is_sep[i]  = valid[i] && store_q[i] == gwlm_pkg::ChSep;
			any_one[i] = store_q[i] == gwlm_pkg::ChOne;
			eq[i]      = fold(store_q[i], case_sensitive) == char_f;
		end
	end

	// An alternative ends at the fill count or just before a separator; an
	// end straight after a separator (or at the start) is an empty one.
	always_comb begin
		info.accept[0] = 1'b0;
		for (int i = 1; i <= gwlm_pkg::PatLen; i++) begin
			if (i < gwlm_pkg::PatLen) begin
				info.accept[i] = (count_q == gwlm_pkg::CntW'(i) || is_sep[i])
					&& store_q[i-1] != gwlm_pkg::ChSep;
			end else begin
				info.accept[i] = count_q == gwlm_pkg::CntW'(i)
					&& store_q[i-1] != gwlm_pkg::ChSep;
			end
		end
	end

	assign info.start    = {is_sep, 1'b1};
	assign info.prop     = {is_star, 1'b0};
	assign info.star     = is_star;
	assign info.lit      = valid & ~is_star & ~is_sep & (any_one | eq);
	assign info.overflow = overflow_q;

endmodule

// ===== rtl/core/gwlm_nfa.sv =====
// ----------------------------------------------------------------------------
// gwlm_nfa - active position vector of the pattern automaton
// Advances the position bits by one subject byte per beat and evaluates the
// match condition for the end-of-subject beat.
// ----------------------------------------------------------------------------
module gwlm_nfa (
	input  logic                clk,
	input  logic                arst_n,
	input  gwlm_pkg::nfa_ctrl_t ctrl,
	input  gwlm_pkg::pat_info_t info,
	output logic                matched
);

	logic [gwlm_pkg::PosN-1:0] active_q;
	logic                      fresh_q;
	logic [gwlm_pkg::PosN-1:0] start_vec;
	logic [gwlm_pkg::PosN-1:0] cur;
	logic [gwlm_pkg::PosN-1:0] moved;
	logic [gwlm_pkg::PosN-1:0] next_vec;

	// Every active star also activates the position after it; runs of stars
	// are covered by a parallel prefix over the propagate bits.
	function automatic logic [gwlm_pkg::PosN-1:0] close_stars(
		input logic [gwlm_pkg::PosN-1:0] v,
		input logic [gwlm_pkg::PosN-1:0] t
	);
		logic [gwlm_pkg::PosN-1:0] acc;
		logic [gwlm_pkg::PosN-1:0] prop;
		acc  = v;
		prop = t;
		for (int k = 0; k < gwlm_pkg::PropLvl; k++) begin
			acc  = acc | (prop & (acc << (1 << k)));
			prop = prop & (prop << (1 << k));
		end
		return acc;
	endfunction

	assign start_vec = close_stars(info.start, info.prop);
	assign cur       = fresh_q ? start_vec : active_q;

	always_comb begin
		moved = '0;
		for (int i = 0; i < gwlm_pkg::PatLen; i++) begin
			moved[i]   = moved[i] | (cur[i] & info.star[i]);
			moved[i+1] = cur[i] & info.lit[i];
		end
	end

	assign next_vec = close_stars(moved, info.prop);
	assign matched  = |(cur & info.accept);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			fresh_q  <= 1'b1;
		end else if (ctrl.restart) begin
			active_q <= '0;
			fresh_q  <= 1'b1;
		end else if (ctrl.step) begin
			active_q <= next_vec;
			fresh_q  <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/glob_wildcard_list_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// glob_wildcard_list_matcher_unit - streaming wildcard pattern-list matcher
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries one command beat: clear the
// pattern, append a pattern byte, feed a subject byte or end the subject.
// Pattern alternatives are separated by ';', '*' matches any run of bytes
// and '?' any one byte. Only an end-of-subject beat gives a result on the
// output channel (out_valid/out_ready): matched and pattern_overflow.
// A beat is taken into an input register and worked on from there, where
// the position vector and the result register are updated. One beat is
// taken every cycle unless an end-of-subject beat has to wait for room.
// While a result waits in the output register, other beats still proceed;
// only a further end-of-subject beat holds in the input register until the
// receiver takes the pending result. Reset empties the pattern, clears the
// overflow flag, starts a fresh subject and sets case_sensitive to 0, so
// letter case is ignored. cfg_wr_en writes case_sensitive; the user must
// do so only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module glob_wildcard_list_matcher_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       matched,
	output logic       pattern_overflow
);

	logic                  case_sensitive_q;
	logic                  valid_s1;
	gwlm_pkg::cmd_t        cmd_s1;
	logic [7:0]            char_s1;
	logic                  out_valid_q;
	logic                  matched_q;
	logic                  overflow_q;

	logic                  advance;
	logic                  nfa_matched;
	gwlm_pkg::store_ctrl_t store_ctrl;
	gwlm_pkg::nfa_ctrl_t   nfa_ctrl;
	gwlm_pkg::pat_info_t   info;

	// An end-of-subject beat needs room in the output register.
	assign advance  = valid_s1
		&& (cmd_s1 != gwlm_pkg::CMD_END || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_sensitive_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case_sensitive_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1  <= gwlm_pkg::cmd_t'(cmd);
			char_s1 <= char_code;
		end
	end

	always_comb begin
		store_ctrl.clear  = 1'b0;
		store_ctrl.append = 1'b0;
		store_ctrl.wdata  = char_s1;
		nfa_ctrl.restart  = 1'b0;
		nfa_ctrl.step     = 1'b0;
		if (advance) begin
			unique case (cmd_s1)
				gwlm_pkg::CMD_CLEAR: begin
					store_ctrl.clear = 1'b1;
					nfa_ctrl.restart = 1'b1;
				end
				gwlm_pkg::CMD_APPEND: begin
					store_ctrl.append = 1'b1;
					nfa_ctrl.restart  = 1'b1;
				end
				gwlm_pkg::CMD_SUBJECT: begin
					nfa_ctrl.step = 1'b1;
				end
				gwlm_pkg::CMD_END: begin
					nfa_ctrl.restart = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	gwlm_pattern_store u_store (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (store_ctrl),
		.char_code      (char_s1),
		.case_sensitive (case_sensitive_q),
		.info           (info)
	);

	gwlm_nfa u_nfa (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (nfa_ctrl),
		.info    (info),
		.matched (nfa_matched)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && cmd_s1 == gwlm_pkg::CMD_END) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cmd_s1 == gwlm_pkg::CMD_END) begin
			matched_q  <= nfa_matched;
			overflow_q <= info.overflow;
		end
	end

	assign out_valid        = out_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = overflow_q;

endmodule

// ===== test/glob_wildcard_list_matcher_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glob_wildcard_list_matcher_unit_checker - result checker for the matcher
// Watches the command and result channels and the case_sensitive write port.
// It keeps its own copy of the pattern and the active-position vector,
// predicts the verdict of every end-of-subject beat and compares it with
// the result beats in order.
// ----------------------------------------------------------------------------
module glob_wildcard_list_matcher_unit_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] cmd,
	input  logic [7:0] char_code,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       matched,
	input  logic       pattern_overflow,
	output int         fail_count,
	output int         outstanding,
	output int         results_seen,
	output int         matches_seen,
	output int         overflows_seen
);

	import gwlm_pkg::*;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	verdict_t        expected_verdicts[$];
	logic [7:0]      pat_mem [PatLen];
	int              pat_len;
	logic [PosN-1:0] live;
	logic            fresh;
	logic            ovf_flag;
	logic            case_sens;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (!case_sens && c >= ChUpA && c <= ChUpZ) begin
			return c + CaseBit;
		end
		return c;
	endfunction

	// An active star also makes the position after it active, in a chain.
	function automatic void spread_stars();
		for (int i = 0; i < pat_len; i++) begin
			if (live[i] && pat_mem[i] == ChStar) begin
				live[i+1] = 1'b1;
			end
		end
	endfunction

	function automatic void begin_subject();
		live    = '0;
		live[0] = 1'b1;
		for (int i = 0; i < pat_len; i++) begin
			if (pat_mem[i] == ChSep) begin
				live[i+1] = 1'b1;
			end
		end
		spread_stars();
		fresh = 1'b0;
	endfunction

	function automatic void consume_byte(input logic [7:0] c);
		logic [PosN-1:0] nxt;
		nxt = '0;
		for (int i = 0; i < pat_len; i++) begin
			if (live[i]) begin
				if (pat_mem[i] == ChStar) begin
					nxt[i] = 1'b1;
				end else if (pat_mem[i] != ChSep &&
				             (pat_mem[i] == ChOne || fold_case(pat_mem[i]) == fold_case(c))) begin
					nxt[i+1] = 1'b1;
				end
			end
		end
		live = nxt;
		spread_stars();
	endfunction

	// An alternative is complete when the position at its end is active and
	// the alternative holds at least one byte.
	function automatic logic any_alt_complete();
		for (int i = 1; i <= pat_len; i++) begin
			if ((i == pat_len || pat_mem[i] == ChSep) && live[i] && pat_mem[i-1] != ChSep) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void apply_beat(input cmd_t c, input logic [7:0] ch);
		verdict_t v;
		case (c)
			CMD_CLEAR: begin
				pat_len  = 0;
				ovf_flag = 1'b0;
				live     = '0;
				fresh    = 1'b1;
			end
			CMD_APPEND: begin
				if (pat_len < PatLen) begin
					pat_mem[pat_len] = ch;
					pat_len++;
				end else begin
					ovf_flag = 1'b1;
				end
				live  = '0;
				fresh = 1'b1;
			end
			CMD_SUBJECT: begin
				if (fresh) begin
					begin_subject();
				end
				consume_byte(ch);
			end
			CMD_END: begin
				if (fresh) begin
					begin_subject();
				end
				v.matched  = any_alt_complete();
				v.overflow = ovf_flag;
				expected_verdicts = {expected_verdicts, v};
				live  = '0;
				fresh = 1'b1;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_result();
		verdict_t want;
		results_seen++;
		if (matched) begin
			matches_seen++;
		end
		if (pattern_overflow) begin
			overflows_seen++;
		end
		if (expected_verdicts.size() == 0) begin
			report_mismatch($sformatf("result beat with none expected (matched=%0b overflow=%0b)",
			                          matched, pattern_overflow));
		end else begin
			want = expected_verdicts.pop_front();
			if (matched !== want.matched) begin
				report_mismatch($sformatf("matched is %0b, expected %0b", matched, want.matched));
			end
			if (pattern_overflow !== want.overflow) begin
				report_mismatch($sformatf("pattern_overflow is %0b, expected %0b",
				                          pattern_overflow, want.overflow));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_verdicts.delete();
			pat_len        = 0;
			live           = '0;
			fresh          = 1'b1;
			ovf_flag       = 1'b0;
			case_sens      = 1'b0;
			fail_count     = 0;
			outstanding    = 0;
			results_seen   = 0;
			matches_seen   = 0;
			overflows_seen = 0;
		end else begin
			// The result side is looked at first: a beat taken on this edge
			// cannot have produced the result seen on it.
			if (out_valid && out_ready) begin
				check_result();
			end
			if (in_valid && in_ready) begin
				apply_beat(cmd_t'(cmd), char_code);
			end
			if (cfg_wr_en) begin
				case_sens = cfg_wr_data;
			end
			outstanding = expected_verdicts.size();
		end
	end

endmodule

// ===== test/glob_wildcard_list_matcher_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glob_wildcard_list_matcher_unit_test - top level of the matcher testbench
// Drives command beats into the matcher: a short directed run, then random
// pattern lists and subjects, many of them built from the pattern so that
// matches are common, mixed with stray commands and case mode changes.
// Both channels idle at random; a separate checker judges every result.
// ----------------------------------------------------------------------------
module glob_wildcard_list_matcher_unit_test;

	import gwlm_pkg::*;

	localparam int TotalBeats = 1170;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic       cfg_wr_data;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] cmd;
	logic [7:0] char_code;
	logic       out_valid;
	logic       out_ready;
	logic       matched;
	logic       pattern_overflow;

	int fail_count;
	int outstanding;
	int results_seen;
	int matches_seen;
	int overflows_seen;

	int         beats_sent = 0;
	bit         idle_on    = 1'b1;
	logic [7:0] pat_sent[$];
	logic [7:0] subj_buf[$];

	glob_wildcard_list_matcher_unit DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.char_code        (char_code),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

	glob_wildcard_list_matcher_unit_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.char_code        (char_code),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.matched          (matched),
		.pattern_overflow (pattern_overflow),
		.fail_count       (fail_count),
		.outstanding      (outstanding),
		.results_seen     (results_seen),
		.matches_seen     (matches_seen),
		.overflows_seen   (overflows_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(8_000_000);
		$display("glob_wildcard_list_matcher_unit: mismatch");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Receiver: short ready runs and stalls, with long stretches of no stall.
	initial begin
		forever begin
			if ($urandom_range(0, 9) == 0) begin
				out_ready <= 1'b1;
				repeat (200) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	function automatic logic [7:0] pick_pat_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			return ChStar;
		end else if (r < 35) begin
			return ChOne;
		end else if (r < 45) begin
			return ChSep;
		end else if (r < 90) begin
			case ($urandom_range(0, 3))
				0:       return "a";
				1:       return "b";
				2:       return "A";
				default: return "B";
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_subj_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			case ($urandom_range(0, 3))
				0:       return "a";
				1:       return "b";
				2:       return "A";
				default: return "B";
			endcase
		end else if (r < 70) begin
			return ChSep;
		end else if (r < 80) begin
			return $urandom_range(0, 1) ? ChStar : ChOne;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_beat(input cmd_t c, input logic [7:0] ch);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		char_code <= ch;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
		// Keep a copy of the pattern as the block holds it, for building subjects.
		if (c == CMD_CLEAR) begin
			pat_sent.delete();
		end else if (c == CMD_APPEND && pat_sent.size() < PatLen) begin
			pat_sent = {pat_sent, ch};
		end
	endtask

	// Stop sending until every expected result is back and the block is quiet.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_case_mode(input logic v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic build_pattern();
		int len;
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			len = $urandom_range(0, 6);
		end else if (r < 9) begin
			len = $urandom_range(7, PatLen);
		end else begin
			len = $urandom_range(PatLen, PatLen + 4);
		end
		// Sometimes the list grows on top of the old one, without a clear.
		if ($urandom_range(0, 4) != 0) begin
			send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
		end
		repeat (len) send_beat(CMD_APPEND, pick_pat_char());
	endtask

	// Most subjects are an instance of one alternative, some of them spoilt.
	task automatic make_subject();
		int         starts[$];
		int         k;
		logic [7:0] c;
		subj_buf.delete();
		if (pat_sent.size() == 0 || $urandom_range(0, 3) == 0) begin
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5))
				subj_buf = {subj_buf, pick_subj_char()};
		end else begin
			for (int i = 0; i < pat_sent.size(); i++) begin
				if (i == 0 || pat_sent[i-1] == ChSep) begin
					starts = {starts, i};
				end
			end
			k = starts[$urandom_range(0, starts.size() - 1)];
			while (k < pat_sent.size() && pat_sent[k] != ChSep) begin
				c = pat_sent[k];
				if (c == ChStar) begin
					repeat ($urandom_range(0, 2)) subj_buf = {subj_buf, pick_subj_char()};
				end else if (c == ChOne) begin
					subj_buf = {subj_buf, pick_subj_char()};
				end else begin
					if ((c | CaseBit) >= "a" && (c | CaseBit) <= "z" && $urandom_range(0, 9) < 3) begin
						c = c ^ CaseBit;
					end
					subj_buf = {subj_buf, c};
				end
				k++;
			end
			if ($urandom_range(0, 4) == 0) begin
				if (subj_buf.size() > 0 && $urandom_range(0, 1) == 1) begin
					subj_buf[$urandom_range(0, subj_buf.size() - 1)] = pick_subj_char();
				end else begin
					subj_buf = {subj_buf, pick_subj_char()};
				end
			end
		end
	endtask

	task automatic run_subject();
		foreach (subj_buf[i]) begin
			send_beat(CMD_SUBJECT, subj_buf[i]);
		end
		send_beat(CMD_END, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int r;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		cmd         <= CMD_CLEAR;
		char_code   <= 8'h00;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty pattern never matches; a star-only alternative takes an empty subject.
		send_beat(CMD_END, 8'hFF);
		send_beat(CMD_APPEND, ChStar);
		send_beat(CMD_END, 8'h00);
		// Pattern "a?;" with a trailing empty alternative; ';' in the subject is ordinary.
		send_beat(CMD_CLEAR, 8'hFF);
		send_beat(CMD_APPEND, "a");
		send_beat(CMD_APPEND, ChOne);
		send_beat(CMD_APPEND, ChSep);
		send_beat(CMD_SUBJECT, "A");
		send_beat(CMD_SUBJECT, ChSep);
		send_beat(CMD_END, 8'h00);
		// An append in mid-subject abandons it; the zero byte is a normal character.
		send_beat(CMD_SUBJECT, "a");
		send_beat(CMD_APPEND, 8'h00);
		send_beat(CMD_SUBJECT, 8'h00);
		send_beat(CMD_END, 8'h00);
		send_beat(CMD_SUBJECT, 8'hFF);
		send_beat(CMD_END, 8'hFF);
		// With exact comparison the letter case now matters.
		set_case_mode(1'b1);
		send_beat(CMD_SUBJECT, "A");
		send_beat(CMD_SUBJECT, "x");
		send_beat(CMD_END, 8'h00);
		send_beat(CMD_SUBJECT, "a");
		send_beat(CMD_SUBJECT, "Z");
		send_beat(CMD_END, 8'h00);
		set_case_mode(1'b0);

		while (beats_sent < TotalBeats) begin
			r = $urandom_range(0, 99);
			if (r < 14) begin
				build_pattern();
			end else if (r < 84) begin
				make_subject();
				run_subject();
			end else if (r < 95) begin
				send_beat(cmd_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
			end else if (r < 98) begin
				set_case_mode(1'($urandom_range(0, 1)));
			end else begin
				drain();
			end
			if ($urandom_range(0, 99) == 0) begin
				idle_on = !idle_on;
			end
		end

		drain();
		repeat (10) @(posedge clk);
		$display("Sent %0d command beats: directed cases, random pattern lists up to overflow,",
		         beats_sent);
		$display("case folding on and off; %0d results checked, %0d matched, %0d overflow flagged.",
		         results_seen, matches_seen, overflows_seen);
		if (fail_count == 0) begin
			$display("glob_wildcard_list_matcher_unit: match");
		end else begin
			$display("glob_wildcard_list_matcher_unit: mismatch");
		end
		$finish;
	end

endmodule

// ===== glob_wildcard_list_matcher_unit.f =====
rtl/core/gwlm_pkg.sv
rtl/core/gwlm_pattern_store.sv
rtl/core/gwlm_nfa.sv
rtl/core/glob_wildcard_list_matcher_unit.sv
test/glob_wildcard_list_matcher_unit_checker.sv
test/glob_wildcard_list_matcher_unit_test.sv
